// ===== hw/rtl/strict_base64_decoder_top_defines.svh =====
// Assertion macros shared by the decoder RTL files.
`ifndef STRICT_BASE64_DECODER_TOP_DEFINES_SVH
`define STRICT_BASE64_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SB64_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sb64 assertion failed");

// Next-cycle implication, checked outside reset.
`define SB64_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sb64 assertion failed");

`endif

// ===== hw/rtl/sb64_pkg.sv =====
// Types, constants and the alphabet lookup of the strict base64 decoder.
`timescale 1ns / 1ps

package sb64_pkg;

   localparam int unsigned LIMIT_W     = 27;
   localparam int unsigned CSR_ADDR_W  = 3;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned QUEUE_DEPTH = 8;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned MAX_PUSH    = 4;
   localparam int unsigned PUSH_W      = $clog2(MAX_PUSH + 1);

   localparam logic [LIMIT_W-1:0] MAX_BYTES_RESET = LIMIT_W'(67108864);

   localparam logic [6:0] SEXTET_PAD = 7'd64;
   localparam logic [6:0] SEXTET_BAD = 7'd65;

   localparam logic [7:0] CHAR_PAD   = 8'h3d;
   localparam logic [7:0] CHAR_PLUS  = 8'h2b;
   localparam logic [7:0] CHAR_SLASH = 8'h2f;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_CHAR  = 3'd1,
      ST_BAD_PAD   = 3'd2,
      ST_BAD_LEN   = 3'd3,
      ST_TOO_LONG  = 3'd4
   } status_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_status;
      status_type status;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [PUSH_W-1:0]          count;
      rsp_type [MAX_PUSH-1:0]     entry;
   } push_type;

   // 0..63 for alphabet characters, SEXTET_PAD for '=', SEXTET_BAD otherwise
   function automatic logic [6:0] sextet_of(input logic [7:0] c);
      logic [6:0] v;
      case (c) inside
         ["A":"Z"]:  v = 7'(c - 8'h41);
         ["a":"z"]:  v = 7'(c - 8'h61 + 8'd26);
         ["0":"9"]:  v = 7'(c - 8'h30 + 8'd52);
         CHAR_PLUS:  v = 7'd62;
         CHAR_SLASH: v = 7'd63;
         CHAR_PAD:   v = SEXTET_PAD;
         default:    v = SEXTET_BAD;
      endcase
      return v;
   endfunction

endpackage

// ===== hw/rtl/sb64_core.sv =====
// Group assembly, checks and result generation for one registered item.
`timescale 1ns / 1ps
`include "strict_base64_decoder_top_defines.svh"

module sb64_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  sb64_pkg::req_type             item,
   input  logic [sb64_pkg::LIMIT_W-1:0]  max_bytes,
   output sb64_pkg::push_type            push
);

   logic [1:0]                   pos_ff, pos_in;
   logic [17:0]                  acc_ff, acc_in;
   logic [1:0]                   pad_ff, pad_in;
   sb64_pkg::status_type         err_ff, err_in;
   logic [sb64_pkg::LIMIT_W-1:0] cnt_ff, cnt_in;

   logic [6:0]                   sext;
   logic [5:0]                   v;
   logic [23:0]                  word;
   logic [1:0]                   nbytes;
   logic [1:0]                   nemit;
   logic                         emit;
   logic                         eot;
   logic [sb64_pkg::LIMIT_W:0]   sum;
   logic [7:0]                   bytes [4];
   sb64_pkg::push_type           push_c;

   assign eot = item.end_of_text;

   always_comb begin
      sext   = sb64_pkg::sextet_of(item.char_code);
      v      = sext[5:0];
      pos_in = pos_ff;
      acc_in = acc_ff;
      pad_in = pad_ff;
      cnt_in = cnt_ff;
      err_in = err_ff;
      word   = '0;
      nbytes = '0;
      emit   = 1'b0;
      sum    = '0;
      if (err_ff == sb64_pkg::ST_OK) begin
         if (sext == sb64_pkg::SEXTET_BAD) begin
            err_in = sb64_pkg::ST_BAD_CHAR;
         end else if (sext == sb64_pkg::SEXTET_PAD) begin
            if (pos_ff < 2'd2) begin
               err_in = sb64_pkg::ST_BAD_PAD;
            end else begin
               pad_in = pad_ff + 2'd1;
            end
            v = '0;
         end else if (pad_ff != 2'd0) begin
            err_in = sb64_pkg::ST_BAD_PAD;
         end
         if (err_in == sb64_pkg::ST_OK) begin
            if (pos_ff != 2'd3) begin
               acc_in = {acc_ff[11:0], v};
               pos_in = pos_ff + 2'd1;
            end else begin
               word   = {acc_ff, v};
               nbytes = 2'd3 - pad_in;
               sum    = {1'b0, cnt_ff} + (sb64_pkg::LIMIT_W + 1)'(nbytes);
               if (pad_in != 2'd0 && !eot) begin
                  err_in = sb64_pkg::ST_BAD_PAD;
               end else if (sum > {1'b0, max_bytes}) begin
                  err_in = sb64_pkg::ST_TOO_LONG;
               end else begin
                  emit   = 1'b1;
                  cnt_in = sum[sb64_pkg::LIMIT_W-1:0];
               end
               pos_in = '0;
               acc_in = '0;
               pad_in = '0;
            end
            if (err_in == sb64_pkg::ST_OK && eot && pos_in != 2'd0) begin
               err_in = sb64_pkg::ST_BAD_LEN;
            end
         end
      end
   end

   always_comb begin
      bytes[0] = word[23:16];
      bytes[1] = word[15:8];
      bytes[2] = word[7:0];
      bytes[3] = 8'h00;
      nemit    = emit ? nbytes : 2'd0;
      push_c.count = fire ? (sb64_pkg::PUSH_W'(nemit) + sb64_pkg::PUSH_W'(eot))
                          : '0;
      for (int k = 0; k < sb64_pkg::MAX_PUSH; k++) begin
         if (2'(k) < nemit && k < 3) begin
            push_c.entry[k].data_byte = bytes[k];
            push_c.entry[k].is_status = 1'b0;
            push_c.entry[k].status    = sb64_pkg::ST_OK;
            push_c.entry[k].last      = 1'b0;
         end else begin
            push_c.entry[k].data_byte = 8'h00;
            push_c.entry[k].is_status = 1'b1;
            push_c.entry[k].status    = err_in;
            push_c.entry[k].last      = 1'b1;
         end
      end
   end

   assign push = push_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         acc_ff <= '0;
         pad_ff <= '0;
         err_ff <= sb64_pkg::ST_OK;
         cnt_ff <= '0;
      end else if (fire) begin
         if (eot) begin
            pos_ff <= '0;
            acc_ff <= '0;
            pad_ff <= '0;
            err_ff <= sb64_pkg::ST_OK;
            cnt_ff <= '0;
         end else begin
            pos_ff <= pos_in;
            acc_ff <= acc_in;
            pad_ff <= pad_in;
            err_ff <= err_in;
            cnt_ff <= cnt_in;
         end
      end
   end

   `SB64_ASSERT_NEXT(a_eot_clears, fire && eot, pos_ff == 2'd0 && err_ff == sb64_pkg::ST_OK && cnt_ff == '0)
   `SB64_ASSERT_NEXT(a_err_sticky, fire && !eot && err_ff != sb64_pkg::ST_OK, $stable(err_ff))
   `SB64_ASSERT_NOW(a_no_data_after_err, fire && err_ff != sb64_pkg::ST_OK, push.count == sb64_pkg::PUSH_W'(eot))
   `SB64_ASSERT_NOW(a_push_bound, 1'b1, push.count <= sb64_pkg::PUSH_W'(sb64_pkg::MAX_PUSH))

endmodule

// ===== hw/rtl/sb64_queue.sv =====
// Result queue: takes up to 4 items per cycle, gives 1 per cycle unless stalled.
`timescale 1ns / 1ps
`include "strict_base64_decoder_top_defines.svh"

module sb64_queue (
   input  logic                clock,
   input  logic                reset,
   input  sb64_pkg::push_type  push,
   output logic                room,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output sb64_pkg::rsp_type   rsp_item
);

   sb64_pkg::rsp_type              mem_ff [sb64_pkg::QUEUE_DEPTH];
   logic [sb64_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [sb64_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [sb64_pkg::QCNT_W-1:0]    count_ff, count_in;
   logic [sb64_pkg::QCNT_W:0]      fill_sum;
   logic                           pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_item  = mem_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign room      = (count_ff <= sb64_pkg::QCNT_W'(sb64_pkg::QUEUE_DEPTH -
                                                      sb64_pkg::MAX_PUSH));
   assign fill_sum  = {1'b0, count_ff} + (sb64_pkg::QCNT_W + 1)'(push.count);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + sb64_pkg::QPTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + sb64_pkg::QPTR_W'(pop);
      count_in  = count_ff + sb64_pkg::QCNT_W'(push.count) - sb64_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < sb64_pkg::MAX_PUSH; k++) begin
         if (push.count > sb64_pkg::PUSH_W'(k)) begin
            mem_ff[wr_ptr_ff + sb64_pkg::QPTR_W'(k)] <= push.entry[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `SB64_ASSERT_NOW(a_no_overflow, 1'b1, fill_sum <= (sb64_pkg::QCNT_W+1)'(sb64_pkg::QUEUE_DEPTH))
   `SB64_ASSERT_NOW(a_ptr_gap, 1'b1, sb64_pkg::QPTR_W'(wr_ptr_ff - rd_ptr_ff) == sb64_pkg::QPTR_W'(count_ff))
   `SB64_ASSERT_NEXT(a_drain, pop && push.count == '0, count_ff == $past(count_ff) - sb64_pkg::QCNT_W'(1))

endmodule

// ===== hw/rtl/strict_base64_decoder_top.sv =====
// Top level of the strict base64 decoder: input register, register port, core and queue.
//
//   channel | ports               | carries
//   --------+---------------------+-----------------------------------------
//   request | req_valid/req_stall | req_item: one character, end-of-text flag
//   result  | rsp_valid/rsp_stall | rsp_item: data byte or end-of-text status
//   config  | csr_* (APB style)   | max_decoded_bytes at byte address 0
//
// While req_stall is low, one character per cycle enters the input register to be decoded.
// A character is decoded only while the result queue has room for four items.
// Results go to the queue memory, which drains one item per cycle while rsp_stall is low.
// A group with end of text yields up to four items, so a stalled result side stops input.
// Synchronous reset clears control state; max_decoded_bytes resets to 67108864.
`timescale 1ns / 1ps

module strict_base64_decoder_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  sb64_pkg::req_type                   req_item,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output sb64_pkg::rsp_type                   rsp_item,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sb64_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [sb64_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [sb64_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   logic                          in_valid_ff, in_valid_in;
   sb64_pkg::req_type             in_item_ff;
   logic [sb64_pkg::LIMIT_W-1:0]  max_bytes_ff, max_bytes_in;
   logic                          room;
   logic                          fire;
   logic                          accept;
   logic                          csr_wr;
   sb64_pkg::push_type            push;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == 1'b0)
                       ? sb64_pkg::CSR_DATA_W'(max_bytes_ff) : '0;

   assign fire      = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = accept ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
      max_bytes_in = (csr_wr && csr_paddr[2] == 1'b0)
                     ? csr_pwdata[sb64_pkg::LIMIT_W-1:0] : max_bytes_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         max_bytes_ff <= sb64_pkg::MAX_BYTES_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         max_bytes_ff <= max_bytes_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= req_item;
      end
   end

   sb64_core u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .item      (in_item_ff),
      .max_bytes (max_bytes_ff),
      .push      (push)
   );

   sb64_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule
